// File: hdl/rgb_3x3_blur_sharpen_filter_macros.svh
// ----------------------------------------------------------------------------
// rgb_3x3_blur_sharpen_filter_macros
// Assertion macros shared by the filter modules. Both expect clk and rst in scope.
// ----------------------------------------------------------------------------
`ifndef RGB_3X3_BLUR_SHARPEN_FILTER_MACROS_SVH
`define RGB_3X3_BLUR_SHARPEN_FILTER_MACROS_SVH

// same-cycle check
`define RBSF_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("rbsf assertion failed");

// next-cycle check
`define RBSF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rbsf assertion failed");

`endif

// File: hdl/rbsf_pkg.sv
// ----------------------------------------------------------------------------
// rbsf_pkg
// Types and constants for the 3x3 RGB blur/sharpen filter.
// ----------------------------------------------------------------------------
package rbsf_pkg;

  localparam int MAX_SIZE = 1024;
  localparam int MIN_SIZE = 3;
  localparam int IDX_W    = 10;
  localparam int SIZE_W   = 11;
  localparam int CH_W     = 8;
  localparam int NCH      = 3;
  localparam int NWIN     = 9;
  localparam int WIN_CTR  = 4;
  localparam int LUMA_W   = 10;
  localparam int SUM_W    = 12;
  localparam int SHARP_W  = 13;
  localparam int RECIP_W  = 13;
  localparam int RECIP_SH = 15;
  localparam int PROD_W   = SUM_W + RECIP_W;
  localparam int QDEPTH   = 4;
  localparam int QPTR_W   = 2;
  localparam int QCNT_W   = 3;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  // reciprocals scaled by 2^15, exact after truncation for the sum ranges used
  localparam logic [RECIP_W-1:0] RECIP9 = 13'd3641;
  localparam logic [RECIP_W-1:0] RECIP7 = 13'd4682;
  localparam logic [CH_W-1:0]    CH_MAX = 8'd255;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd512;

  localparam logic [1:0] MODE_BOX   = 2'd0;
  localparam logic [1:0] MODE_SHARP = 2'd1;
  localparam logic [1:0] MODE_TRIM  = 2'd2;

  localparam logic REG_IMAGE_SIZE = 1'b0;
  localparam logic REG_MODE       = 1'b1;

  typedef enum logic [1:0] {
    OP_BOX   = 2'd0,
    OP_SHARP = 2'd1,
    OP_TRIM  = 2'd2
  } op_t;

  // channel 0 red, 1 green, 2 blue
  typedef logic [NCH-1:0][CH_W-1:0] pixel_t;

  typedef struct packed {
    logic [CH_W-1:0] in_red;
    logic [CH_W-1:0] in_green;
    logic [CH_W-1:0] in_blue;
  } in_t;

  typedef struct packed {
    logic [CH_W-1:0]  out_red;
    logic [CH_W-1:0]  out_green;
    logic [CH_W-1:0]  out_blue;
    logic [IDX_W-1:0] out_row;
    logic [IDX_W-1:0] out_col;
  } out_t;

  typedef struct packed {
    pixel_t top;
    pixel_t mid;
  } line_t;

  typedef struct packed {
    pixel_t [NWIN-1:0] win;
    op_t               op;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
  } job_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              empty;
  } qstat_t;

endpackage

// File: hdl/rbsf_front.sv
// ----------------------------------------------------------------------------
// rbsf_front
// Pixel intake: raster counters, two-row line memory, 3x3 window, job issue.
// ----------------------------------------------------------------------------
`include "rgb_3x3_blur_sharpen_filter_macros.svh"

module rbsf_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         pixel_valid,
  output logic                         pixel_stall,
  input  rbsf_pkg::in_t                pixel,
  input  logic [rbsf_pkg::SIZE_W-1:0]  image_size,
  input  logic [1:0]                   mode,
  input  rbsf_pkg::qstat_t             qstat,
  output logic                         push,
  output rbsf_pkg::job_t               job
);

  rbsf_pkg::line_t line_mem [rbsf_pkg::MAX_SIZE];
  rbsf_pkg::line_t rd;

  logic [rbsf_pkg::IDX_W-1:0] col_count, row_count;
  logic [rbsf_pkg::IDX_W-1:0] col_count_next, row_count_next;
  logic [rbsf_pkg::IDX_W-1:0] last;
  logic                       accept;

  logic                       s_valid;
  logic                       s_emit;
  rbsf_pkg::pixel_t           s_pix;
  logic [rbsf_pkg::IDX_W-1:0] s_col;
  logic [rbsf_pkg::IDX_W-1:0] s_orow, s_ocol;
  rbsf_pkg::op_t              s_op;
  rbsf_pkg::op_t              op;

  rbsf_pkg::pixel_t win      [rbsf_pkg::NWIN];
  rbsf_pkg::pixel_t win_next [rbsf_pkg::NWIN];

  assign accept = pixel_valid && !pixel_stall;
  assign pixel_stall = ({1'b0, qstat.count} + rbsf_pkg::QCNT_W'(s_valid && s_emit))
                       >= (rbsf_pkg::QCNT_W+1)'(rbsf_pkg::QDEPTH);

  always_comb begin
    if (image_size < rbsf_pkg::SIZE_W'(rbsf_pkg::MIN_SIZE)) begin
      last = rbsf_pkg::IDX_W'(rbsf_pkg::MIN_SIZE - 1);
    end else if (image_size > rbsf_pkg::SIZE_W'(rbsf_pkg::MAX_SIZE)) begin
      last = rbsf_pkg::IDX_W'(rbsf_pkg::MAX_SIZE - 1);
    end else begin
      last = rbsf_pkg::IDX_W'(image_size - 1'b1);
    end
  end

  always_comb begin
    if (col_count >= last) begin
      col_count_next = '0;
      row_count_next = (row_count >= last) ? '0 : row_count + 1'b1;
    end else begin
      col_count_next = col_count + 1'b1;
      row_count_next = row_count;
    end
  end

  always_comb begin
    unique case (mode)
      rbsf_pkg::MODE_SHARP: op = rbsf_pkg::OP_SHARP;
      rbsf_pkg::MODE_TRIM:  op = rbsf_pkg::OP_TRIM;
      default:              op = rbsf_pkg::OP_BOX;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
      s_valid   <= 1'b0;
      s_emit    <= 1'b0;
    end else begin
      s_valid <= accept;
      if (accept) begin
        col_count <= col_count_next;
        row_count <= row_count_next;
        s_emit    <= (row_count >= rbsf_pkg::IDX_W'(2)) && (col_count >= rbsf_pkg::IDX_W'(2));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s_pix  <= {pixel.in_blue, pixel.in_green, pixel.in_red};
      s_col  <= col_count;
      s_orow <= row_count - 1'b1;
      s_ocol <= col_count - 1'b1;
      s_op   <= op;
    end
  end

  // line memory: read at intake, write back in the following cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      rd <= line_mem[col_count];
    end
    if (s_valid) begin
      line_mem[s_col] <= '{top: rd.mid, mid: s_pix};
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_next[3*r]   = win[3*r+1];
      win_next[3*r+1] = win[3*r+2];
    end
    win_next[2] = rd.top;
    win_next[5] = rd.mid;
    win_next[8] = s_pix;
  end

  always_ff @(posedge clk) begin
    if (s_valid) begin
      win <= win_next;
    end
  end

  assign push = s_valid && s_emit;

  always_comb begin
    for (int k = 0; k < rbsf_pkg::NWIN; k++) begin
      job.win[k] = win_next[k];
    end
    job.op  = s_op;
    job.row = s_orow;
    job.col = s_ocol;
  end

  `RBSF_ASSERT(a_no_rw_collide, !(s_valid && accept) || (col_count != s_col))
  `RBSF_ASSERT(a_push_room, !push || (qstat.count < rbsf_pkg::QCNT_W'(rbsf_pkg::QDEPTH)))

endmodule

// File: hdl/rbsf_queue.sv
// ----------------------------------------------------------------------------
// rbsf_queue
// Short job queue between window intake and the arithmetic pipeline.
// ----------------------------------------------------------------------------
`include "rgb_3x3_blur_sharpen_filter_macros.svh"

module rbsf_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  rbsf_pkg::job_t    push_job,
  input  logic              pop,
  output rbsf_pkg::job_t    head,
  output rbsf_pkg::qstat_t  qstat
);

  rbsf_pkg::job_t              slots [rbsf_pkg::QDEPTH];
  logic [rbsf_pkg::QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [rbsf_pkg::QCNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  assign head        = slots[rd_ptr];
  assign qstat.count = count;
  assign qstat.empty = (count == '0);

  `RBSF_ASSERT(a_no_overflow, !push || (count != rbsf_pkg::QCNT_W'(rbsf_pkg::QDEPTH)) || pop)
  `RBSF_ASSERT(a_no_underflow, !pop || (count != '0))

endmodule

// File: hdl/rbsf_back.sv
// ----------------------------------------------------------------------------
// rbsf_back
// Four-stage filter arithmetic: sums and luma, extreme search, trim, scale.
// ----------------------------------------------------------------------------
`include "rgb_3x3_blur_sharpen_filter_macros.svh"

module rbsf_back (
  input  logic              clk,
  input  logic              rst,
  input  rbsf_pkg::job_t    head,
  input  rbsf_pkg::qstat_t  qstat,
  output logic              pop,
  output logic              result_valid,
  input  logic              result_stall,
  output rbsf_pkg::out_t    result
);

  logic en;

  // stage 1
  logic                                   b1_valid;
  rbsf_pkg::pixel_t                       b1_pix  [rbsf_pkg::NWIN];
  logic [rbsf_pkg::LUMA_W-1:0]            b1_luma [rbsf_pkg::NWIN];
  logic [rbsf_pkg::SUM_W-1:0]             b1_tot  [rbsf_pkg::NCH];
  rbsf_pkg::op_t                          b1_op;
  logic [rbsf_pkg::IDX_W-1:0]             b1_row, b1_col;

  // stage 2
  logic                                   b2_valid;
  rbsf_pkg::pixel_t                       b2_pix  [rbsf_pkg::NWIN];
  logic [rbsf_pkg::SUM_W-1:0]             b2_tot  [rbsf_pkg::NCH];
  logic signed [rbsf_pkg::SHARP_W-1:0]    b2_sharp [rbsf_pkg::NCH];
  logic [rbsf_pkg::NWIN-1:0]              b2_hi, b2_lo;
  rbsf_pkg::op_t                          b2_op;
  logic [rbsf_pkg::IDX_W-1:0]             b2_row, b2_col;

  // stage 3
  logic                                   b3_valid;
  logic [rbsf_pkg::SUM_W-1:0]             b3_num   [rbsf_pkg::NCH];
  logic signed [rbsf_pkg::SHARP_W-1:0]    b3_sharp [rbsf_pkg::NCH];
  rbsf_pkg::op_t                          b3_op;
  logic [rbsf_pkg::IDX_W-1:0]             b3_row, b3_col;

  logic [rbsf_pkg::LUMA_W-1:0]            luma  [rbsf_pkg::NWIN];
  logic [rbsf_pkg::SUM_W-1:0]             tot   [rbsf_pkg::NCH];
  logic signed [rbsf_pkg::SHARP_W-1:0]    sharp [rbsf_pkg::NCH];
  logic [rbsf_pkg::NWIN-1:0]              hi_mask, lo_mask;
  logic [rbsf_pkg::SUM_W-1:0]             num   [rbsf_pkg::NCH];
  logic [rbsf_pkg::CH_W-1:0]              p_hi, p_lo;
  logic [rbsf_pkg::RECIP_W-1:0]           recip;
  logic [rbsf_pkg::PROD_W-1:0]            prod  [rbsf_pkg::NCH];
  logic [rbsf_pkg::CH_W-1:0]              chan  [rbsf_pkg::NCH];

  assign en  = !(result_valid && result_stall);
  assign pop = en && !qstat.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid     <= 1'b0;
      b2_valid     <= 1'b0;
      b3_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else if (en) begin
      b1_valid     <= pop;
      b2_valid     <= b1_valid;
      b3_valid     <= b2_valid;
      result_valid <= b3_valid;
    end
  end

  // stage 1: channel sums and luma
  always_comb begin
    for (int k = 0; k < rbsf_pkg::NWIN; k++) begin
      luma[k] = rbsf_pkg::LUMA_W'(head.win[k][0]) + rbsf_pkg::LUMA_W'(head.win[k][1])
              + rbsf_pkg::LUMA_W'(head.win[k][2]);
    end
    for (int c = 0; c < rbsf_pkg::NCH; c++) begin
      tot[c] = '0;
      for (int k = 0; k < rbsf_pkg::NWIN; k++) begin
        tot[c] = tot[c] + rbsf_pkg::SUM_W'(head.win[k][c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < rbsf_pkg::NWIN; k++) begin
        b1_pix[k]  <= head.win[k];
        b1_luma[k] <= luma[k];
      end
      b1_tot <= tot;
      b1_op  <= head.op;
      b1_row <= head.row;
      b1_col <= head.col;
    end
  end

  // stage 2: first strict maximum and last minimum, sharpen term
  always_comb begin
    for (int k = 0; k < rbsf_pkg::NWIN; k++) begin
      hi_mask[k] = 1'b1;
      lo_mask[k] = 1'b1;
      for (int j = 0; j < rbsf_pkg::NWIN; j++) begin
        if (j < k) begin
          if (!(b1_luma[k] > b1_luma[j]))  hi_mask[k] = 1'b0;
          if (!(b1_luma[k] <= b1_luma[j])) lo_mask[k] = 1'b0;
        end else if (j > k) begin
          if (!(b1_luma[k] >= b1_luma[j])) hi_mask[k] = 1'b0;
          if (!(b1_luma[k] < b1_luma[j]))  lo_mask[k] = 1'b0;
        end
      end
    end
    for (int c = 0; c < rbsf_pkg::NCH; c++) begin
      sharp[c] = $signed(rbsf_pkg::SHARP_W'({b1_pix[rbsf_pkg::WIN_CTR][c], 3'b000}))
               + $signed(rbsf_pkg::SHARP_W'({b1_pix[rbsf_pkg::WIN_CTR][c], 1'b0}))
               - $signed(rbsf_pkg::SHARP_W'(b1_tot[c]));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b2_pix   <= b1_pix;
      b2_tot   <= b1_tot;
      b2_sharp <= sharp;
      b2_hi    <= hi_mask;
      b2_lo    <= lo_mask;
      b2_op    <= b1_op;
      b2_row   <= b1_row;
      b2_col   <= b1_col;
    end
  end

  // stage 3: remove extremes for the trimmed mean
  always_comb begin
    for (int c = 0; c < rbsf_pkg::NCH; c++) begin
      p_hi = '0;
      p_lo = '0;
      for (int k = 0; k < rbsf_pkg::NWIN; k++) begin
        p_hi = p_hi | (b2_pix[k][c] & {rbsf_pkg::CH_W{b2_hi[k]}});
        p_lo = p_lo | (b2_pix[k][c] & {rbsf_pkg::CH_W{b2_lo[k]}});
      end
      if (b2_op == rbsf_pkg::OP_TRIM) begin
        num[c] = b2_tot[c] - rbsf_pkg::SUM_W'(p_hi) - rbsf_pkg::SUM_W'(p_lo);
      end else begin
        num[c] = b2_tot[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b3_num   <= num;
      b3_sharp <= b2_sharp;
      b3_op    <= b2_op;
      b3_row   <= b2_row;
      b3_col   <= b2_col;
    end
  end

  // stage 4: divide by multiplying with a reciprocal, or clamp the sharpen term
  always_comb begin
    recip = (b3_op == rbsf_pkg::OP_TRIM) ? rbsf_pkg::RECIP7 : rbsf_pkg::RECIP9;
    for (int c = 0; c < rbsf_pkg::NCH; c++) begin
      prod[c] = rbsf_pkg::PROD_W'(b3_num[c]) * rbsf_pkg::PROD_W'(recip);
      if (b3_op == rbsf_pkg::OP_SHARP) begin
        if (b3_sharp[c] < 0) begin
          chan[c] = '0;
        end else if (b3_sharp[c] > $signed(rbsf_pkg::SHARP_W'(rbsf_pkg::CH_MAX))) begin
          chan[c] = rbsf_pkg::CH_MAX;
        end else begin
          chan[c] = b3_sharp[c][rbsf_pkg::CH_W-1:0];
        end
      end else begin
        chan[c] = prod[c][rbsf_pkg::RECIP_SH +: rbsf_pkg::CH_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result.out_red   <= chan[0];
      result.out_green <= chan[1];
      result.out_blue  <= chan[2];
      result.out_row   <= b3_row;
      result.out_col   <= b3_col;
    end
  end

  `RBSF_ASSERT(a_extremes_onehot, !b2_valid || ($onehot(b2_hi) && $onehot(b2_lo)))
  `RBSF_ASSERT_NEXT(a_pop_enters_pipe, pop, b1_valid)

endmodule

// File: hdl/rgb_3x3_blur_sharpen_filter.sv
// ----------------------------------------------------------------------------
// rgb_3x3_blur_sharpen_filter
// Streaming 3x3 RGB filter: box blur, sharpen or trimmed mean over a square image.
// ----------------------------------------------------------------------------
// Pixels enter in raster order and the block takes one pixel per clock while the
// result side keeps up; a result comes out once the pixel that closes its window has
// passed the line-memory read register, the job queue and the four arithmetic stages.
// Border pixels give no result. A four-entry job queue lets intake run on through
// short output stalls. image_size and mode are set over APB at 0x0 and 0x4 and must
// only be changed between frames with the block drained.

module rgb_3x3_blur_sharpen_filter (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          pixel_valid,
  output logic                          pixel_stall,
  input  rbsf_pkg::in_t                 pixel,
  output logic                          result_valid,
  input  logic                          result_stall,
  output rbsf_pkg::out_t                result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rbsf_pkg::APB_AW-1:0]   paddr,
  input  logic [rbsf_pkg::APB_DW-1:0]   pwdata,
  output logic [rbsf_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);

  logic [rbsf_pkg::SIZE_W-1:0] image_size;
  logic [1:0]                  mode;
  logic                        push, pop;
  rbsf_pkg::job_t              push_job, head;
  rbsf_pkg::qstat_t            qstat;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_size <= rbsf_pkg::SIZE_RESET;
      mode       <= rbsf_pkg::MODE_BOX;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        rbsf_pkg::REG_IMAGE_SIZE: image_size <= pwdata[rbsf_pkg::SIZE_W-1:0];
        rbsf_pkg::REG_MODE:       mode       <= pwdata[1:0];
        default:                  mode       <= mode;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      rbsf_pkg::REG_IMAGE_SIZE: prdata = rbsf_pkg::APB_DW'(image_size);
      rbsf_pkg::REG_MODE:       prdata = rbsf_pkg::APB_DW'(mode);
      default:                  prdata = '0;
    endcase
  end

  rbsf_front u_front (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .pixel       (pixel),
    .image_size  (image_size),
    .mode        (mode),
    .qstat       (qstat),
    .push        (push),
    .job         (push_job)
  );

  rbsf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .qstat    (qstat)
  );

  rbsf_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .qstat        (qstat),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

// File: test/tb_rgb_3x3_blur_sharpen_filter.sv
// ----------------------------------------------------------------------------
// tb_rgb_3x3_blur_sharpen_filter
// Self-checking bench for the streaming 3x3 RGB filter. Raster pixels go in
// over valid/stall, image_size and mode are set over APB with the pipe
// drained, and every filtered pixel is compared field by field with a local
// model of line buffers, window and counters. A short directed table comes
// first, then random frames with bursty input and a stalling output side.
// ----------------------------------------------------------------------------
module tb_rgb_3x3_blur_sharpen_filter;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES   = 120;
  localparam int TOTAL_ITEMS   = 1150;
  localparam int OVERSIZE_RUN  = 40;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic [rbsf_pkg::SIZE_W-1:0] size;
    logic [1:0]                  mode;
    rbsf_pkg::in_t               px;
    bit                          known;
    rbsf_pkg::out_t              res;
  } dir_row_t;

  logic                        clk;
  logic                        rst = 1'b1;
  logic                        pixel_valid = 1'b0;
  logic                        pixel_stall;
  rbsf_pkg::in_t               pixel = '0;
  logic                        result_valid;
  logic                        result_stall = 1'b0;
  rbsf_pkg::out_t              result;
  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [rbsf_pkg::APB_AW-1:0] paddr = '0;
  logic [rbsf_pkg::APB_DW-1:0] pwdata = '0;
  logic [rbsf_pkg::APB_DW-1:0] prdata;
  logic                        pready;

  // local copy of the filter state
  rbsf_pkg::pixel_t            line_mem [2*rbsf_pkg::MAX_SIZE];
  rbsf_pkg::pixel_t            win [rbsf_pkg::NWIN];
  int                          col_pos;
  int                          row_pos;
  logic [rbsf_pkg::SIZE_W-1:0] cfg_size;
  logic [1:0]                  cfg_mode;
  rbsf_pkg::out_t              filtered_pixels [$];

  int error_count = 0;
  int items_sent = 0;
  int gap_max = 0;
  int pixel_kind = 0;
  bit hold_req = 1'b0;

  // frame A: flat white box blur, frame B: single bright centre sharpened,
  // frame C: undersized image, trimmed mean with every luma tied
  dir_row_t directed_tbl [27] = '{
    '{11'd3, rbsf_pkg::MODE_BOX,   '{8'd255, 8'd255, 8'd255}, 1'b0, '0},
    '{11'd3, rbsf_pkg::MODE_BOX,   '{8'd255, 8'd255, 8'd255}, 1'b0, '0},
    '{11'd3, rbsf_pkg::MODE_BOX,   '{8'd255, 8'd255, 8'd255}, 1'b0, '0},
    '{11'd3, rbsf_pkg::MODE_BOX,   '{8'd255, 8'd255, 8'd255}, 1'b0, '0},
    '{11'd3, rbsf_pkg::MODE_BOX,   '{8'd255, 8'd255, 8'd255}, 1'b0, '0},
    '{11'd3, rbsf_pkg::MODE_BOX,   '{8'd255, 8'd255, 8'd255}, 1'b0, '0},
    '{11'd3, rbsf_pkg::MODE_BOX,   '{8'd255, 8'd255, 8'd255}, 1'b0, '0},
    '{11'd3, rbsf_pkg::MODE_BOX,   '{8'd255, 8'd255, 8'd255}, 1'b0, '0},
    '{11'd3, rbsf_pkg::MODE_BOX,   '{8'd255, 8'd255, 8'd255}, 1'b1,
      '{8'd255, 8'd255, 8'd255, 10'd1, 10'd1}},
    '{11'd3, rbsf_pkg::MODE_SHARP, '{8'd0, 8'd255, 8'd0}, 1'b0, '0},
    '{11'd3, rbsf_pkg::MODE_SHARP, '{8'd0, 8'd255, 8'd0}, 1'b0, '0},
    '{11'd3, rbsf_pkg::MODE_SHARP, '{8'd0, 8'd255, 8'd0}, 1'b0, '0},
    '{11'd3, rbsf_pkg::MODE_SHARP, '{8'd0, 8'd255, 8'd0}, 1'b0, '0},
    '{11'd3, rbsf_pkg::MODE_SHARP, '{8'd255, 8'd0, 8'd0}, 1'b0, '0},
    '{11'd3, rbsf_pkg::MODE_SHARP, '{8'd0, 8'd255, 8'd0}, 1'b0, '0},
    '{11'd3, rbsf_pkg::MODE_SHARP, '{8'd0, 8'd255, 8'd0}, 1'b0, '0},
    '{11'd3, rbsf_pkg::MODE_SHARP, '{8'd0, 8'd255, 8'd0}, 1'b0, '0},
    '{11'd3, rbsf_pkg::MODE_SHARP, '{8'd0, 8'd255, 8'd0}, 1'b1,
      '{8'd255, 8'd0, 8'd0, 10'd1, 10'd1}},
    '{11'd0, rbsf_pkg::MODE_TRIM,  '{8'd100, 8'd100, 8'd100}, 1'b0, '0},
    '{11'd0, rbsf_pkg::MODE_TRIM,  '{8'd255, 8'd45, 8'd0}, 1'b0, '0},
    '{11'd0, rbsf_pkg::MODE_TRIM,  '{8'd0, 8'd45, 8'd255}, 1'b0, '0},
    '{11'd0, rbsf_pkg::MODE_TRIM,  '{8'd45, 8'd255, 8'd0}, 1'b0, '0},
    '{11'd0, rbsf_pkg::MODE_TRIM,  '{8'd150, 8'd150, 8'd0}, 1'b0, '0},
    '{11'd0, rbsf_pkg::MODE_TRIM,  '{8'd0, 8'd150, 8'd150}, 1'b0, '0},
    '{11'd0, rbsf_pkg::MODE_TRIM,  '{8'd150, 8'd0, 8'd150}, 1'b0, '0},
    '{11'd0, rbsf_pkg::MODE_TRIM,  '{8'd255, 8'd0, 8'd45}, 1'b0, '0},
    '{11'd0, rbsf_pkg::MODE_TRIM,  '{8'd0, 8'd255, 8'd45}, 1'b0, '0}
  };

  rgb_3x3_blur_sharpen_filter uut (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .pixel        (pixel),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic int pixel_luma(input rbsf_pkg::pixel_t p);
    return int'(p[0]) + int'(p[1]) + int'(p[2]);
  endfunction

  task automatic filter_pixel(input rbsf_pkg::in_t px, output bit got,
                              output rbsf_pkg::out_t res);
    rbsf_pkg::pixel_t          cur;
    rbsf_pkg::pixel_t          top;
    rbsf_pkg::pixel_t          mid;
    int                        eff_size;
    int                        hi;
    int                        lo;
    int                        maxv;
    int                        minv;
    int                        v;
    int                        acc [rbsf_pkg::NCH];
    logic [rbsf_pkg::CH_W-1:0] ch [rbsf_pkg::NCH];
    eff_size = cfg_size;
    if (eff_size < rbsf_pkg::MIN_SIZE) eff_size = rbsf_pkg::MIN_SIZE;
    if (eff_size > rbsf_pkg::MAX_SIZE) eff_size = rbsf_pkg::MAX_SIZE;
    cur[0] = px.in_red;
    cur[1] = px.in_green;
    cur[2] = px.in_blue;
    top = line_mem[col_pos];
    mid = line_mem[rbsf_pkg::MAX_SIZE + col_pos];
    line_mem[col_pos] = mid;
    line_mem[rbsf_pkg::MAX_SIZE + col_pos] = cur;
    for (int k = 0; k < rbsf_pkg::NWIN; k += 3) begin
      win[k] = win[k + 1];
      win[k + 1] = win[k + 2];
    end
    win[2] = top;
    win[5] = mid;
    win[8] = cur;
    got = (row_pos >= 2) && (col_pos >= 2);
    res = '0;
    if (got) begin
      case (cfg_mode)
        rbsf_pkg::MODE_SHARP: begin
          for (int c = 0; c < rbsf_pkg::NCH; c++) begin
            acc[c] = 9 * int'(win[rbsf_pkg::WIN_CTR][c]);
            for (int k = 0; k < rbsf_pkg::NWIN; k++)
              if (k != rbsf_pkg::WIN_CTR) acc[c] -= int'(win[k][c]);
          end
        end
        rbsf_pkg::MODE_TRIM: begin
          hi = 0;
          lo = 0;
          maxv = pixel_luma(win[0]);
          minv = maxv;
          for (int k = 1; k < rbsf_pkg::NWIN; k++) begin
            v = pixel_luma(win[k]);
            if (v > maxv) begin
              maxv = v;
              hi = k;
            end
            if (v <= minv) begin
              minv = v;
              lo = k;
            end
          end
          for (int c = 0; c < rbsf_pkg::NCH; c++) begin
            acc[c] = 0;
            for (int k = 0; k < rbsf_pkg::NWIN; k++)
              if (k != hi && k != lo) acc[c] += int'(win[k][c]);
            acc[c] = acc[c] / 7;
          end
        end
        default: begin
          for (int c = 0; c < rbsf_pkg::NCH; c++) begin
            acc[c] = 0;
            for (int k = 0; k < rbsf_pkg::NWIN; k++) acc[c] += int'(win[k][c]);
            acc[c] = acc[c] / 9;
          end
        end
      endcase
      for (int c = 0; c < rbsf_pkg::NCH; c++)
        ch[c] = (acc[c] < 0) ? '0 :
                (acc[c] > 255) ? rbsf_pkg::CH_MAX : rbsf_pkg::CH_W'(acc[c]);
      res.out_red   = ch[0];
      res.out_green = ch[1];
      res.out_blue  = ch[2];
      res.out_row   = rbsf_pkg::IDX_W'(row_pos - 1);
      res.out_col   = rbsf_pkg::IDX_W'(col_pos - 1);
    end
    if (col_pos >= eff_size - 1) begin
      col_pos = 0;
      row_pos = (row_pos >= eff_size - 1) ? 0 : row_pos + 1;
    end else begin
      col_pos++;
    end
  endtask

  function automatic rbsf_pkg::in_t random_pixel();
    rbsf_pkg::in_t px;
    case (pixel_kind)
      0: begin
        px.in_red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        px.in_green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        px.in_blue  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end
      1: begin
        px.in_red   = rbsf_pkg::CH_W'($urandom_range(0, 3));
        px.in_green = rbsf_pkg::CH_W'($urandom_range(0, 3));
        px.in_blue  = rbsf_pkg::CH_W'($urandom_range(0, 3));
      end
      default: px = rbsf_pkg::in_t'(24'($urandom));
    endcase
    return px;
  endfunction

  task automatic idle(input int n);
    pixel_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic send_pixel(input rbsf_pkg::in_t px, output bit got,
                            output rbsf_pkg::out_t res);
    pixel <= px;
    pixel_valid <= 1'b1;
    @(posedge clk);
    while (pixel_stall !== 1'b0) @(posedge clk);
    filter_pixel(px, got, res);
    items_sent++;
  endtask

  // count pixels, or up to the end of the current frame
  task automatic stream_pixels(input int count, input bit to_frame_end);
    int             sent;
    int             burst_left;
    bit             got;
    rbsf_pkg::out_t res;
    sent = 0;
    burst_left = $urandom_range(1, 40);
    while (to_frame_end ? !(sent > 0 && row_pos == 0 && col_pos == 0) : sent < count) begin
      if (burst_left == 0) begin
        if (gap_max > 0) idle($urandom_range(1, gap_max));
        burst_left = $urandom_range(1, 40);
      end
      send_pixel(random_pixel(), got, res);
      if (got) filtered_pixels.push_back(res);
      sent++;
      burst_left--;
    end
  endtask

  task automatic drain();
    pixel_valid <= 1'b0;
    while (filtered_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic reg_idx,
                            input logic [rbsf_pkg::APB_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= wr ? data : '0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    if (!wr && prdata !== data) begin
      error_count++;
      $display("%0t: register %0d read: expected %0h, actual %0h", $time, reg_idx, data,
               prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [rbsf_pkg::SIZE_W-1:0] size,
                            input logic [1:0] mode);
    if (size != cfg_size || mode != cfg_mode) begin
      drain();
      if (size != cfg_size) begin
        apb_access(1'b1, rbsf_pkg::REG_IMAGE_SIZE,
                   ($urandom & ~32'h7FF) | rbsf_pkg::APB_DW'(size));
        cfg_size = size;
        apb_access(1'b0, rbsf_pkg::REG_IMAGE_SIZE, rbsf_pkg::APB_DW'(size));
      end
      if (mode != cfg_mode) begin
        apb_access(1'b1, rbsf_pkg::REG_MODE, ($urandom & ~32'h3) | rbsf_pkg::APB_DW'(mode));
        cfg_mode = mode;
        apb_access(1'b0, rbsf_pkg::REG_MODE, rbsf_pkg::APB_DW'(mode));
      end
    end
  endtask

  task automatic check_field(input string name, input logic [rbsf_pkg::IDX_W-1:0] want,
                             input logic [rbsf_pkg::IDX_W-1:0] got);
    if (got !== want) begin
      error_count++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    rbsf_pkg::out_t want;
    if (rst === 1'b0 && result_valid === 1'b1 && result_stall === 1'b0) begin
      if (filtered_pixels.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result: expected none, actual %p", $time, result);
      end else begin
        want = filtered_pixels.pop_front();
        check_field("out_red", rbsf_pkg::IDX_W'(want.out_red),
                    rbsf_pkg::IDX_W'(result.out_red));
        check_field("out_green", rbsf_pkg::IDX_W'(want.out_green),
                    rbsf_pkg::IDX_W'(result.out_green));
        check_field("out_blue", rbsf_pkg::IDX_W'(want.out_blue),
                    rbsf_pkg::IDX_W'(result.out_blue));
        check_field("out_row", want.out_row, result.out_row);
        check_field("out_col", want.out_col, result.out_col);
      end
    end
  end

  // output side: random stall phases, plus one long hold-off on request
  initial begin
    int stall_pct;
    int phase_left;
    stall_pct = 0;
    phase_left = 0;
    wait (rst === 1'b0);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        result_stall <= 1'b0;
      end else begin
        if (phase_left == 0) begin
          phase_left = $urandom_range(20, 200);
          case ($urandom_range(0, 4))
            0, 1: stall_pct = 0;
            2: stall_pct = 30;
            3: stall_pct = 60;
            default: stall_pct = 90;
          endcase
        end
        phase_left--;
        result_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  initial begin
    int             target;
    int             sel;
    bit             got;
    rbsf_pkg::out_t res;
    foreach (line_mem[i]) line_mem[i] = '0;
    foreach (win[i]) win[i] = '0;
    col_pos = 0;
    row_pos = 0;
    cfg_size = rbsf_pkg::SIZE_RESET;
    cfg_mode = rbsf_pkg::MODE_BOX;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    apb_access(1'b0, rbsf_pkg::REG_IMAGE_SIZE, rbsf_pkg::APB_DW'(rbsf_pkg::SIZE_RESET));
    apb_access(1'b0, rbsf_pkg::REG_MODE, rbsf_pkg::APB_DW'(rbsf_pkg::MODE_BOX));

    foreach (directed_tbl[i]) begin
      set_config(directed_tbl[i].size, directed_tbl[i].mode);
      send_pixel(directed_tbl[i].px, got, res);
      if (directed_tbl[i].known) filtered_pixels.push_back(directed_tbl[i].res);
      else if (got) filtered_pixels.push_back(res);
    end

    // oversized image runs at MAX_SIZE, then shrinks mid-frame so the column wraps
    pixel_kind = 2;
    gap_max = 0;
    set_config(11'd2047, rbsf_pkg::MODE_SHARP);
    stream_pixels(OVERSIZE_RUN, 1'b0);
    set_config(11'd5, rbsf_pkg::MODE_TRIM);
    stream_pixels(0, 1'b1);

    target = TOTAL_ITEMS;

    // long output hold-off with the input running flat out
    set_config(11'd12, rbsf_pkg::MODE_BOX);
    hold_req = 1'b1;
    stream_pixels(0, 1'b1);

    // mode switch in the middle of a frame
    gap_max = 3;
    set_config(11'd8, rbsf_pkg::MODE_SHARP);
    stream_pixels(30, 1'b0);
    set_config(11'd8, MODE_UNUSED);
    stream_pixels(0, 1'b1);

    while (items_sent < target) begin
      sel = $urandom_range(0, 29);
      pixel_kind = $urandom_range(0, 5);
      case ($urandom_range(0, 3))
        0, 1: gap_max = 0;
        2: gap_max = 3;
        default: gap_max = 8;
      endcase
      if (sel < 3) begin
        set_config(rbsf_pkg::SIZE_W'($urandom_range(0, 2)), 2'($urandom_range(0, 3)));
      end else if (sel == 3) begin
        set_config(11'd24, 2'($urandom_range(0, 3)));
      end else begin
        set_config(rbsf_pkg::SIZE_W'($urandom_range(3, 12)), 2'($urandom_range(0, 3)));
      end
      stream_pixels(0, 1'b1);
    end

    drain();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
